// ===== hw/rtl/qltt_pkg.sv =====
// qltt_pkg: shared constants and helpers for the trickle timer with q-learning
// stand-alone package, used by q_learning_trickle_timer

package qltt_pkg;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // design constants
  localparam int unsigned QUEUE_DEPTH   = 20;
  localparam int unsigned STATE_CLASSES = 3;
  localparam int unsigned QTAB_DEPTH    = STATE_CLASSES * STATE_CLASSES * 2;
  localparam int unsigned QTAB_AW       = $clog2(QTAB_DEPTH);
  localparam logic [16:0] ONE_Q16       = 17'h10000;
  // class edges: p*3 < 1.0 and p*3 < 2.0 in q1.16
  localparam logic [16:0] KLASS_LO      = 17'd21845;
  localparam logic [16:0] KLASS_HI      = 17'd43690;

  // command codes
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_START   = 3'd1;
  localparam logic [2:0] FN_STOP    = 3'd2;
  localparam logic [2:0] FN_HEARD   = 3'd3;
  localparam logic [2:0] FN_RESET   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_IVL   = 3'd0;
  localparam logic [2:0] CFG_DOUBLINGS = 3'd1;
  localparam logic [2:0] CFG_BASE_RED  = 3'd2;
  localparam logic [2:0] CFG_SLOTFRAME = 3'd3;
  localparam logic [2:0] CFG_EXPLORE   = 3'd4;
  localparam logic [2:0] CFG_ALPHA     = 3'd5;
  localparam logic [2:0] CFG_GAMMA     = 3'd6;
  localparam logic [2:0] CFG_LEARN_ON  = 3'd7;

  // configuration reset values
  localparam logic [15:0] RST_MIN_IVL   = 16'd1000;
  localparam logic [4:0]  RST_DOUBLINGS = 5'd8;
  localparam logic [7:0]  RST_BASE_RED  = 8'd10;
  localparam logic [15:0] RST_SLOTFRAME = 16'd1010;
  localparam logic [15:0] RST_EXPLORE   = 16'd6554;
  localparam logic [15:0] RST_ALPHA     = 16'd32768;
  localparam logic [15:0] RST_GAMMA     = 16'd58982;

  // ratio class: low, mid, high
  function automatic logic [1:0] klass(input logic [16:0] p);
    logic [1:0] k;
    if (p <= KLASS_LO) k = 2'd0;
    else if (p <= KLASS_HI) k = 2'd1;
    else k = 2'd2;
    return k;
  endfunction

  // q-table address from busy class, queue class and action
  function automatic logic [QTAB_AW-1:0] qidx(input logic [1:0] s1, input logic [1:0] s2,
                                              input logic act);
    logic [QTAB_AW-1:0] a;
    a = QTAB_AW'((QTAB_AW'(s1) * QTAB_AW'(STATE_CLASSES) + QTAB_AW'(s2)) * QTAB_AW'(2))
        + QTAB_AW'(act);
    return a;
  endfunction

endpackage

// ===== hw/rtl/q_learning_trickle_timer.sv =====
// q_learning_trickle_timer: trickle timer with a small q-learning send policy
// depends on qltt_pkg; one sequencer around a shared divider and multiplier
//
// Usage: each request on the slave stream carries a command in tuser (tick,
// start, stop, consistent heard, reset) and the sampled link figures in
// tdata. Every request gives exactly one response on the master stream with
// the send decision, interval-end flag, window flag, interval length, current
// redundancy, busy ratio, running flag and accepted flag.
// Configuration must be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// Stop, consistent, plain ticks and rejected commands go from decode straight
// to the response. Start, reset, a tick at fire time and a tick that closes
// an interval run through the shared radix-2 divider (32 steps for cells per
// interval, 16 steps for each ratio and for the fire-time draw).
// One request is in work at a time: s_axis_tready_o is high only when idle.
// If the receiver stalls, the response holds on the master side and no new
// request is taken. Reset clears the timer, counters, ratios and the q-table
// and restores the configuration defaults.

module q_learning_trickle_timer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // fields from bit 0: rand_draw, ops_valid, ops_count, dio_count_valid,
  // dio_failed, dio_total, queue_used, neighbour_count, zero pad
  input  logic [qltt_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // fields from bit 0: func
  input  logic [qltt_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // fields from bit 0: send_dio, interval_ended, in_window, interval_ms,
  // redundancy_now, busy_ratio, running, accepted, zero pad
  output logic [qltt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_we_i,
  input  logic [qltt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qltt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import qltt_pkg::*;

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_FIRE0 = 5'd2;
  localparam logic [4:0] S_FIRE1 = 5'd3;
  localparam logic [4:0] S_FIRE2 = 5'd4;
  localparam logic [4:0] S_FTX   = 5'd5;
  localparam logic [4:0] S_END0  = 5'd6;
  localparam logic [4:0] S_END1  = 5'd7;
  localparam logic [4:0] S_END2  = 5'd8;
  localparam logic [4:0] S_END3  = 5'd9;
  localparam logic [4:0] S_END4  = 5'd10;
  localparam logic [4:0] S_Q0    = 5'd11;
  localparam logic [4:0] S_Q1    = 5'd12;
  localparam logic [4:0] S_Q2    = 5'd13;
  localparam logic [4:0] S_Q3    = 5'd14;
  localparam logic [4:0] S_Q4    = 5'd15;
  localparam logic [4:0] S_Q5    = 5'd16;
  localparam logic [4:0] S_Q6    = 5'd17;
  localparam logic [4:0] S_DBL   = 5'd18;
  localparam logic [4:0] S_ST0   = 5'd19;
  localparam logic [4:0] S_ST1   = 5'd20;
  localparam logic [4:0] S_ST2   = 5'd21;
  localparam logic [4:0] S_ST3   = 5'd22;
  localparam logic [4:0] S_ST4   = 5'd23;
  localparam logic [4:0] S_RST1  = 5'd24;
  localparam logic [4:0] S_DIV   = 5'd25;
  localparam logic [4:0] S_OUT   = 5'd26;

  // configuration
  logic [15:0] min_ivl_q, sf_q, expl_q, alpha_q, gamma_q;
  logic [4:0]  dbl_q;
  logic [7:0]  base_q;
  logic        learn_q;

  // latched request
  logic [2:0]  func_q;
  logic [15:0] rand_q, ops_q, fail_q, tot_q;
  logic        opsv_q, dcv_q;
  logic [7:0]  qu_q, nbr_q;

  // timer state
  logic [4:0]  state_q, state_d;
  logic        run_q, run_d;
  logic [31:0] ilen_q, ilen_d, el_q, el_d, fire_q, fire_d, ws_q, ws_d, we_q, we_d;
  logic [15:0] heard_q, heard_d;
  logic [31:0] icnt_q, icnt_d, rcnt_q, rcnt_d, sent_q, sent_d;
  logic [16:0] snap_q, snap_d;
  logic [7:0]  red_q, red_d;
  logic [16:0] pbusy_q, pbusy_d, psent_q, psent_d, pqu_q, pqu_d;
  logic [16:0] pbusyp_q, pbusyp_d, psentp_q, psentp_d, pqup_q, pqup_d;
  logic [16:0] preset_q, preset_d, ptx_q, ptx_d;
  logic        last_q, last_d;

  // per-request flags
  logic        hit_q, hit_d, endf_q, endf_d, greedy_q, greedy_d;
  logic        send_q, send_d, ended_q, ended_d, acc_q, acc_d;

  // q-table
  logic signed [15:0] qtab_q [QTAB_DEPTH];
  logic signed [15:0] qrd_q, qt1_q, qt1_d, qt2_q, qt2_d, qwdata;
  logic [QTAB_AW-1:0] qaddr, qwaddr;
  logic               qwe;

  // shared multiplier
  logic signed [33:0] mul_a, gn_q, gn_d;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_q;
  logic signed [53:0] acc54_q, acc54_d, qsum, lrt;
  logic signed [21:0] nv22;

  // shared divider
  logic        dv_go, dv_ratio;
  logic [31:0] dv_num, dv_den;
  logic [4:0]  dv_ret;
  logic [32:0] rem_q, rem_d, vsr_q, vsr_d;
  logic [31:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [4:0]  ret_q, ret_d;
  logic        shrt_q, shrt_d;
  logic [16:0] shrtv_q, shrtv_d;
  logic [33:0] rem_sh;
  logic        rem_ge;
  logic [16:0] ratio_val;

  // helpers
  logic        in_acc, out_acc, in_win;
  logic [31:0] el_inc, fire_tgt, cells, den_busy, we_new, mx_cap;
  logic [30:0] half;
  logic [15:0] used;
  logic [32:0] span, dbl_ni;
  logic [47:0] mx;
  logic [7:0]  mred;
  logic [24:0] kround;
  logic [1:0]  s1, s2, n1, n2;
  logic        rw_pos, rw_neg, busy_ok;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);

  assign in_win = run_q && (el_q >= ws_q) && (el_q < we_q);
  assign m_axis_tdata_o = {2'b00, acc_q, run_q, pbusy_q, red_q, ilen_q, in_win, ended_q, send_q};

  assign ratio_val = shrt_q ? shrtv_q : {1'b0, quo_q[15:0]};
  assign half      = ilen_q[31:1];
  assign el_inc    = (el_q == 32'hFFFF_FFFF) ? el_q : el_q + 32'd1;
  assign fire_tgt  = (fire_q != 32'd0) ? fire_q : 32'd1;
  assign s1 = klass(pbusyp_q);
  assign s2 = klass(pqup_q);
  assign n1 = klass(pbusy_q);
  assign n2 = klass(pqu_q);

  // cells per interval and busy-ratio divisor
  assign cells    = (sf_q == 16'd0) ? 32'd0 : quo_q;
  assign used     = ops_q - snap_q[15:0];
  assign busy_ok  = snap_q[16] & opsv_q & (cells != 32'd0);
  assign den_busy = !busy_ok ? 32'd0 : ((cells < {16'd0, used}) ? {16'd0, used} : cells);

  // interval cap
  assign mx     = 48'(min_ivl_q) << dbl_q;
  assign mx_cap = (mx > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : mx[31:0];
  assign dbl_ni = {ilen_q, 1'b0};

  // learned redundancy limit and window span
  assign mred   = (base_q == 8'd0) ? 8'd0 : ((nbr_q < base_q - 8'd1) ? nbr_q : base_q - 8'd1);
  assign kround = prod_q[24:0] + 25'h000FFFF;
  assign we_new = learn_q ? ({1'b0, half} + prod_q[47:16]) : ilen_q;
  assign span   = {1'b0, we_new} - {1'b0, ws_q} + 33'd1;

  // reward from the sent ratio trend
  assign rw_pos = (psent_q > psentp_q) || (psent_q == ONE_Q16);
  assign rw_neg = (psent_q < psentp_q) || (psent_q == 17'd0);
  assign lrt    = $signed({10'd0, alpha_q, 28'd0});
  assign qsum   = acc54_q + 54'(prod_q);
  assign nv22   = qsum[53:32];

  // divider step
  assign rem_sh = {rem_q, dvd_q[31]};
  assign rem_ge = rem_sh >= {1'b0, vsr_q};

  // sequencer
  always_comb begin
    state_d = state_q;  run_d = run_q;   ilen_d = ilen_q;   el_d = el_q;
    fire_d = fire_q;    ws_d = ws_q;     we_d = we_q;       heard_d = heard_q;
    icnt_d = icnt_q;    rcnt_d = rcnt_q; sent_d = sent_q;   snap_d = snap_q;
    red_d = red_q;      pbusy_d = pbusy_q; psent_d = psent_q; pqu_d = pqu_q;
    pbusyp_d = pbusyp_q; psentp_d = psentp_q; pqup_d = pqup_q;
    preset_d = preset_q; ptx_d = ptx_q;  last_d = last_q;
    hit_d = hit_q;  endf_d = endf_q;  greedy_d = greedy_q;
    send_d = send_q; ended_d = ended_q; acc_d = acc_q;
    qt1_d = qt1_q;  qt2_d = qt2_q;  gn_d = gn_q;  acc54_d = acc54_q;
    qaddr = '0;  qwe = 1'b0;  qwaddr = '0;  qwdata = '0;
    mul_a = '0;  mul_b = '0;
    dv_go = 1'b0;  dv_ratio = 1'b1;  dv_num = '0;  dv_den = '0;  dv_ret = S_OUT;
    rem_d = rem_q;  dvd_d = dvd_q;  vsr_d = vsr_q;  quo_d = quo_q;  cnt_d = cnt_q;
    ret_d = ret_q;  shrt_d = shrt_q;  shrtv_d = shrtv_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DEC;
      end
      // command decode
      S_DEC: begin
        send_d = 1'b0;  ended_d = 1'b0;  acc_d = 1'b1;  state_d = S_OUT;
        case (func_q)
          FN_TICK: begin
            if (run_q) begin
              el_d   = el_inc;
              hit_d  = (el_inc == fire_tgt);
              endf_d = (el_inc >= ilen_q);
              if (el_inc == fire_tgt) state_d = S_FIRE0;
              else if (el_inc >= ilen_q) state_d = S_END0;
            end
          end
          FN_START: begin
            run_d = 1'b1;  ilen_d = {16'd0, min_ivl_q};  state_d = S_ST0;
          end
          FN_STOP: begin
            if (run_q) run_d = 1'b0;
            else acc_d = 1'b0;
          end
          FN_HEARD: begin
            heard_d = (heard_q == 16'hFFFF) ? heard_q : heard_q + 16'd1;
          end
          FN_RESET: begin
            if (run_q) begin
              rcnt_d = (rcnt_q == 32'hFFFF_FFFF) ? rcnt_q : rcnt_q + 32'd1;
              ilen_d = {16'd0, min_ivl_q};
              dv_go = 1'b1;  dv_num = rcnt_d;  dv_den = icnt_q;  dv_ret = S_RST1;
            end else begin
              acc_d = 1'b0;
            end
          end
          default: acc_d = 1'b0;
        endcase
      end
      S_RST1: begin
        preset_d = ratio_val;  state_d = S_ST0;
      end
      // fire time: read both actions of the current state
      S_FIRE0: begin
        greedy_d = learn_q && (rand_q >= expl_q);
        qaddr = qidx(s1, s2, 1'b1);  state_d = S_FIRE1;
      end
      S_FIRE1: begin
        qt1_d = qrd_q;  qaddr = qidx(s1, s2, 1'b0);  state_d = S_FIRE2;
      end
      S_FIRE2: begin
        send_d = greedy_q ? (qt1_q > qrd_q) : (heard_q < {8'd0, red_q});
        last_d = send_d;
        if (send_d) sent_d = (sent_q == 32'hFFFF_FFFF) ? sent_q : sent_q + 32'd1;
        dv_go = 1'b1;  dv_num = sent_d;  dv_den = icnt_q;  dv_ret = S_FTX;
      end
      S_FTX: begin
        ptx_d = ratio_val;
        state_d = endf_q ? S_END0 : S_OUT;
      end
      // interval end: cells, busy, sent and queue ratios
      S_END0: begin
        ended_d = 1'b1;
        dv_go = 1'b1;  dv_ratio = 1'b0;  dv_ret = S_END1;
      end
      S_END1: begin
        dv_go = 1'b1;  dv_num = {16'd0, used};  dv_den = den_busy;  dv_ret = S_END2;
      end
      S_END2: begin
        pbusy_d = ratio_val;
        dv_go = 1'b1;  dv_num = {16'd0, fail_q};  dv_den = {16'd0, tot_q};  dv_ret = S_END3;
      end
      S_END3: begin
        psent_d = (!dcv_q || tot_q == 16'd0) ? 17'd0 : ONE_Q16 - ratio_val;
        dv_go = 1'b1;  dv_num = {24'd0, qu_q};  dv_den = 32'(QUEUE_DEPTH);  dv_ret = S_END4;
      end
      S_END4: begin
        pqu_d = ratio_val;
        state_d = learn_q ? S_Q0 : S_DBL;
      end
      // q update
      S_Q0: begin
        qaddr = qidx(n1, n2, 1'b0);  state_d = S_Q1;
      end
      S_Q1: begin
        qt1_d = qrd_q;  qaddr = qidx(n1, n2, 1'b1);  state_d = S_Q2;
      end
      S_Q2: begin
        if (qrd_q > qt1_q) qt1_d = qrd_q;
        qaddr = qidx(s1, s2, last_q);  state_d = S_Q3;
      end
      S_Q3: begin
        qt2_d = qrd_q;
        mul_a = 34'(qt1_q);  mul_b = $signed({2'b00, gamma_q});  state_d = S_Q4;
      end
      S_Q4: begin
        gn_d  = prod_q[33:0];
        mul_a = 34'(qt2_q);  mul_b = $signed({1'b0, ONE_Q16 - {1'b0, alpha_q}});
        state_d = S_Q5;
      end
      S_Q5: begin
        acc54_d = (54'(prod_q) <<< 16) + (rw_pos ? lrt : (rw_neg ? -lrt : 54'sd0));
        mul_a = gn_q;  mul_b = $signed({2'b00, alpha_q});  state_d = S_Q6;
      end
      S_Q6: begin
        qwe = 1'b1;  qwaddr = qidx(s1, s2, last_q);
        if (nv22 > 22'sd32767) qwdata = 16'sh7FFF;
        else if (nv22 < -22'sd32768) qwdata = 16'sh8000;
        else qwdata = nv22[15:0];
        state_d = S_DBL;
      end
      S_DBL: begin
        ilen_d = (dbl_ni > {1'b0, mx_cap}) ? mx_cap : dbl_ni[31:0];
        state_d = S_ST0;
      end
      // interval start
      S_ST0: begin
        icnt_d = (icnt_q == 32'hFFFF_FFFF) ? icnt_q : icnt_q + 32'd1;
        if (learn_q) begin
          pbusyp_d = pbusy_q;  psentp_d = psent_q;  pqup_d = pqu_q;
        end
        heard_d = 16'd0;
        mul_a = $signed({26'd0, mred});  mul_b = $signed({1'b0, preset_q});
        state_d = S_ST1;
      end
      S_ST1: begin
        red_d = learn_q ? kround[23:16] + 8'd1 : base_q;
        mul_a = $signed({3'd0, half});  mul_b = $signed({1'b0, ptx_q});
        state_d = S_ST2;
      end
      S_ST2: begin
        ws_d  = learn_q ? prod_q[47:16] : {1'b0, half};
        mul_a = $signed({3'd0, half});  mul_b = $signed({1'b0, ONE_Q16 - preset_q});
        state_d = S_ST3;
      end
      S_ST3: begin
        we_d  = we_new;
        dv_go = 1'b1;  dv_ratio = 1'b0;  dv_ret = S_ST4;
      end
      S_ST4: begin
        fire_d = rem_q[31:0] + ws_q;
        snap_d = opsv_q ? {1'b1, ops_q} : 17'd0;
        el_d   = 32'd0;
        state_d = S_OUT;
      end
      // shared radix-2 divider
      S_DIV: begin
        rem_d = rem_ge ? 33'(rem_sh - {1'b0, vsr_q}) : rem_sh[32:0];
        dvd_d = {dvd_q[30:0], 1'b0};
        quo_d = {quo_q[30:0], rem_ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = ret_q;
      end
      S_OUT: begin
        if (out_acc) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // divider launch: ratios may short-cut, cells and fire draw run in full
    if (dv_go) begin
      ret_d = dv_ret;  quo_d = '0;  shrt_d = 1'b0;  shrtv_d = '0;
      if (!dv_ratio) begin
        rem_d = '0;
        if (state_q == S_END0) begin
          dvd_d = ilen_q;  vsr_d = {17'd0, sf_q};  cnt_d = 6'd32;
        end else begin
          dvd_d = {rand_q, 16'd0};  vsr_d = span;  cnt_d = 6'd16;
        end
        state_d = S_DIV;
      end else if (dv_den == 32'd0) begin
        shrt_d = 1'b1;  state_d = dv_ret;
      end else if (dv_num >= dv_den) begin
        shrt_d = 1'b1;  shrtv_d = ONE_Q16;  state_d = dv_ret;
      end else begin
        rem_d = {1'b0, dv_num};  dvd_d = '0;  vsr_d = {1'b0, dv_den};  cnt_d = 6'd16;
        state_d = S_DIV;
      end
    end
  end

  // control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  run_q <= 1'b0;  ilen_q <= '0;  el_q <= '0;  fire_q <= '0;
      ws_q <= '0;  we_q <= '0;  heard_q <= '0;  icnt_q <= '0;  rcnt_q <= '0;
      sent_q <= '0;  snap_q <= '0;  red_q <= RST_BASE_RED;
      pbusy_q <= '0;  psent_q <= '0;  pqu_q <= '0;
      pbusyp_q <= '0;  psentp_q <= '0;  pqup_q <= '0;  preset_q <= '0;  ptx_q <= '0;
      last_q <= 1'b0;  hit_q <= 1'b0;  endf_q <= 1'b0;  greedy_q <= 1'b0;
      send_q <= 1'b0;  ended_q <= 1'b0;  acc_q <= 1'b0;
      cnt_q <= '0;  ret_q <= S_OUT;  shrt_q <= 1'b0;
      for (int i = 0; i < QTAB_DEPTH; i++) qtab_q[i] <= '0;
    end else begin
      state_q <= state_d;  run_q <= run_d;  ilen_q <= ilen_d;  el_q <= el_d;
      fire_q <= fire_d;  ws_q <= ws_d;  we_q <= we_d;  heard_q <= heard_d;
      icnt_q <= icnt_d;  rcnt_q <= rcnt_d;  sent_q <= sent_d;  snap_q <= snap_d;
      red_q <= red_d;  pbusy_q <= pbusy_d;  psent_q <= psent_d;  pqu_q <= pqu_d;
      pbusyp_q <= pbusyp_d;  psentp_q <= psentp_d;  pqup_q <= pqup_d;
      preset_q <= preset_d;  ptx_q <= ptx_d;  last_q <= last_d;
      hit_q <= hit_d;  endf_q <= endf_d;  greedy_q <= greedy_d;
      send_q <= send_d;  ended_q <= ended_d;  acc_q <= acc_d;
      cnt_q <= cnt_d;  ret_q <= ret_d;  shrt_q <= shrt_d;
      if (qwe) qtab_q[qwaddr] <= qwdata;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    qrd_q <= qtab_q[qaddr];
    qt1_q <= qt1_d;  qt2_q <= qt2_d;  gn_q <= gn_d;  acc54_q <= acc54_d;
    prod_q <= mul_a * mul_b;
    rem_q <= rem_d;  dvd_q <= dvd_d;  vsr_q <= vsr_d;  quo_q <= quo_d;
    shrtv_q <= shrtv_d;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser_i;
      rand_q <= s_axis_tdata_i[15:0];
      opsv_q <= s_axis_tdata_i[16];
      ops_q  <= s_axis_tdata_i[32:17];
      dcv_q  <= s_axis_tdata_i[33];
      fail_q <= s_axis_tdata_i[49:34];
      tot_q  <= s_axis_tdata_i[65:50];
      qu_q   <= s_axis_tdata_i[73:66];
      nbr_q  <= s_axis_tdata_i[81:74];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ivl_q <= RST_MIN_IVL;  dbl_q <= RST_DOUBLINGS;  base_q <= RST_BASE_RED;
      sf_q <= RST_SLOTFRAME;  expl_q <= RST_EXPLORE;  alpha_q <= RST_ALPHA;
      gamma_q <= RST_GAMMA;  learn_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_IVL:   min_ivl_q <= cfg_data_i;
        CFG_DOUBLINGS: dbl_q <= cfg_data_i[4:0];
        CFG_BASE_RED:  base_q <= cfg_data_i[7:0];
        CFG_SLOTFRAME: sf_q <= cfg_data_i;
        CFG_EXPLORE:   expl_q <= cfg_data_i;
        CFG_ALPHA:     alpha_q <= cfg_data_i;
        CFG_GAMMA:     gamma_q <= cfg_data_i;
        CFG_LEARN_ON:  learn_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request and response sides open together");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("new request taken while one is in work");

  a_fire_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && run_q) |-> (fire_q >= ws_q && fire_q <= we_q))
    else $error("fire time outside its window");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q != 6'd0))
    else $error("divider running with no steps left");

endmodule
